[sv/qpt_pkg.sv]
// Shared types, register indexes and constants for the quaternion point transform.
package qpt_pkg;

   typedef logic signed [31:0] word_type;
   typedef word_type quat_type [4];
   typedef word_type vec_type [3];

   localparam int CsrIndexWidth = 3;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ROT_X   = 3'd0,
      CSR_ROT_Y   = 3'd1,
      CSR_ROT_Z   = 3'd2,
      CSR_ROT_W   = 3'd3,
      CSR_TRANS_X = 3'd4,
      CSR_TRANS_Y = 3'd5,
      CSR_TRANS_Z = 3'd6
   } csr_index_type;

   // Unit value in Q2.30
   localparam word_type QOne = 32'sh4000_0000;

   // Status of the normalizer seen by the top level
   typedef struct packed {
      logic busy;
   } norm_status_type;

endpackage

[sv/qpt_norm.sv]
// Multi-cycle normalizer: turns the raw quaternion into a unit quaternion in Q2.30.
module qpt_norm (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  qpt_pkg::quat_type        rot,
   output qpt_pkg::norm_status_type status,
   output qpt_pkg::quat_type        unit_q
);

   typedef enum logic [2:0] {
      S_IDLE, S_SHIFT, S_SQUARE, S_SQRT, S_DLOAD, S_DIV
   } state_type;

   state_type         state_ff;
   logic [30:0]       m_ff [4];
   logic [3:0]        neg_ff;
   logic [30:0]       mx_ff;
   logic [1:0]        idx_ff;
   logic [63:0]       acc_ff;
   logic [63:0]       s_ff;
   logic [63:0]       res_ff;
   logic [63:0]       bit_ff;
   logic [5:0]        cnt_ff;
   logic [31:0]       len_ff;
   logic [61:0]       div_ff;
   logic [31:0]       rem_ff;
   logic [31:0]       quo_ff;
   qpt_pkg::quat_type u_ff;

   logic [31:0] mag_in [4];
   logic [30:0] clamp_in [4];
   logic [30:0] max_in;
   logic [61:0] sq_in;
   logic [63:0] acc_in;
   logic [63:0] trial_in;
   logic [32:0] rem_sh_in;
   logic        fit_in;
   logic [31:0] quo_in;

   // Clamp magnitudes and find the largest
   always_comb begin
      max_in = '0;
      for (int i = 0; i < 4; i++) begin
         mag_in[i]   = rot[i][31] ? 32'(-rot[i]) : 32'(rot[i]);
         clamp_in[i] = mag_in[i][31] ? 31'h7FFF_FFFF : mag_in[i][30:0];
         if (clamp_in[i] > max_in) max_in = clamp_in[i];
      end
   end

   // Shared squarer, root trial and divider step
   assign sq_in     = m_ff[idx_ff] * m_ff[idx_ff];
   assign acc_in    = acc_ff + 64'(sq_in);
   assign trial_in  = res_ff + bit_ff;
   assign rem_sh_in = {rem_ff, div_ff[61]};
   assign fit_in    = rem_sh_in >= {1'b0, len_ff};
   assign quo_in    = {quo_ff[30:0], fit_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         u_ff[0]  <= '0;
         u_ff[1]  <= '0;
         u_ff[2]  <= '0;
         u_ff[3]  <= qpt_pkg::QOne;
      end else if (start) begin
         // Load the current registers; a start while busy begins again
         for (int i = 0; i < 4; i++) begin
            m_ff[i]   <= clamp_in[i];
            neg_ff[i] <= rot[i][31];
         end
         mx_ff <= max_in;
         if (max_in == '0) begin
            u_ff[0]  <= '0;
            u_ff[1]  <= '0;
            u_ff[2]  <= '0;
            u_ff[3]  <= qpt_pkg::QOne;
            state_ff <= S_IDLE;
         end else begin
            state_ff <= S_SHIFT;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: ;
            // Scale up until the largest magnitude reaches 2^30
            S_SHIFT: begin
               if (!mx_ff[30]) begin
                  mx_ff <= {mx_ff[29:0], 1'b0};
                  for (int i = 0; i < 4; i++) m_ff[i] <= {m_ff[i][29:0], 1'b0};
               end else begin
                  idx_ff   <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_SQUARE;
               end
            end
            // Accumulate the squared norm
            S_SQUARE: begin
               acc_ff <= acc_in;
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  s_ff     <= acc_in;
                  res_ff   <= '0;
                  bit_ff   <= 64'h4000_0000_0000_0000;
                  cnt_ff   <= '0;
                  state_ff <= S_SQRT;
               end
            end
            // One root bit per cycle
            S_SQRT: begin
               if (s_ff >= trial_in) begin
                  s_ff   <= s_ff - trial_in;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  len_ff   <= s_ff >= trial_in ? 32'((res_ff >> 1) + bit_ff)
                                               : 32'(res_ff >> 1);
                  idx_ff   <= '0;
                  state_ff <= S_DLOAD;
               end
            end
            // Numerator is the magnitude in Q2.30 plus half the length
            S_DLOAD: begin
               div_ff   <= {1'b0, m_ff[idx_ff], 30'd0} + 62'(len_ff >> 1);
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            // One quotient bit per cycle
            S_DIV: begin
               rem_ff <= fit_in ? 32'(rem_sh_in - {1'b0, len_ff}) : rem_sh_in[31:0];
               quo_ff <= quo_in;
               div_ff <= {div_ff[60:0], 1'b0};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd61) begin
                  u_ff[idx_ff] <= neg_ff[idx_ff] ? -quo_in : quo_in;
                  idx_ff       <= idx_ff + 2'd1;
                  state_ff     <= (idx_ff == 2'd3) ? S_IDLE : S_DLOAD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign status.busy = state_ff != S_IDLE;
   assign unit_q      = u_ff;

endmodule

[sv/qpt_rotate.sv]
// Five-stage rotate, translate and saturate pipeline.
module qpt_rotate (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  qpt_pkg::vec_type  p_in,
   input  qpt_pkg::quat_type u,
   input  qpt_pkg::vec_type  t,
   output logic              out_valid,
   output qpt_pkg::vec_type  out_p
);

   logic [4:0] v_ff;

   logic signed [63:0] pr1_ff [6];
   logic signed [31:0] p1_ff [3];
   logic signed [35:0] c1_ff [3];
   logic signed [31:0] p2_ff [3];
   logic signed [71:0] pr3_ff [6];
   logic signed [71:0] w3_ff [3];
   logic signed [31:0] p3_ff [3];
   logic signed [41:0] c2_ff [3];
   logic signed [41:0] wt_ff [3];
   logic signed [31:0] p4_ff [3];
   qpt_pkg::word_type  o_ff [3];

   logic signed [64:0] d1_in [3];
   logic signed [72:0] d2_in [3];
   logic signed [72:0] w_in [3];
   logic signed [47:0] sum_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1_in[i]  = 65'(pr1_ff[2*i]) - 65'(pr1_ff[2*i+1]) + 65'sd536870912;
         d2_in[i]  = 73'(pr3_ff[2*i]) - 73'(pr3_ff[2*i+1]) + 73'sd536870912;
         w_in[i]   = 73'(w3_ff[i]) + 73'sd268435456;
         sum_in[i] = 48'(p4_ff[i]) + 48'(wt_ff[i]) + 48'(c2_ff[i] <<< 1) + 48'(t[i]);
      end
   end

   // Advance every stage together; valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // First cross product terms
         pr1_ff[0] <= u[1] * p_in[2];
         pr1_ff[1] <= u[2] * p_in[1];
         pr1_ff[2] <= u[2] * p_in[0];
         pr1_ff[3] <= u[0] * p_in[2];
         pr1_ff[4] <= u[0] * p_in[1];
         pr1_ff[5] <= u[1] * p_in[0];
         p1_ff     <= p_in;
         // Round first cross product
         for (int i = 0; i < 3; i++) c1_ff[i] <= 36'(d1_in[i] >>> 30);
         p2_ff <= p1_ff;
         // Second cross product and scalar terms
         pr3_ff[0] <= u[1] * c1_ff[2];
         pr3_ff[1] <= u[2] * c1_ff[1];
         pr3_ff[2] <= u[2] * c1_ff[0];
         pr3_ff[3] <= u[0] * c1_ff[2];
         pr3_ff[4] <= u[0] * c1_ff[1];
         pr3_ff[5] <= u[1] * c1_ff[0];
         for (int i = 0; i < 3; i++) w3_ff[i] <= u[3] * c1_ff[i];
         p3_ff <= p2_ff;
         // Round second cross product and the doubled scalar term
         for (int i = 0; i < 3; i++) begin
            c2_ff[i] <= 42'(d2_in[i] >>> 30);
            wt_ff[i] <= 42'(w_in[i] >>> 29);
         end
         p4_ff <= p3_ff;
         // Sum, translate and saturate
         for (int i = 0; i < 3; i++) begin
            if (sum_in[i] > 48'sd2147483647)       o_ff[i] <= 32'sh7FFF_FFFF;
            else if (sum_in[i] < -48'sd2147483648) o_ff[i] <= 32'sh8000_0000;
            else                                   o_ff[i] <= 32'(sum_in[i]);
         end
      end
   end

   assign out_valid = v_ff[4];
   assign out_p     = o_ff;

endmodule

[sv/quaternion_point_transform.sv]
// Top level of the quaternion point transform: registers, normalizer and pipeline.
//
// Points pass through a five-stage pipeline, and one point is taken every cycle while
// the result side does not stall and the normalizer is idle. Writing any rotation
// register (re)starts the normalizer, a sequencer with one shared squarer, a
// one-bit-per-cycle square root and a one-bit-per-cycle divider; it holds req_stall
// while it shifts, sums the squares, takes the root and runs the four divisions
// after the last rotation write. Translation writes take effect at once.
module quaternion_point_transform (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic [31:0] req_point_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   qpt_pkg::quat_type       rot_ff;
   qpt_pkg::vec_type        trans_ff;
   logic                    start_ff;
   qpt_pkg::norm_status_type norm_status;
   qpt_pkg::quat_type       unit_q;
   qpt_pkg::vec_type        p_in;
   qpt_pkg::vec_type        out_p;
   logic                    advance;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0]   <= '0;
         rot_ff[1]   <= '0;
         rot_ff[2]   <= '0;
         rot_ff[3]   <= qpt_pkg::QOne;
         trans_ff[0] <= '0;
         trans_ff[1] <= '0;
         trans_ff[2] <= '0;
         start_ff    <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               qpt_pkg::CSR_ROT_X: begin
                  rot_ff[0] <= csr_wdata;
                  start_ff  <= 1'b1;
               end
               qpt_pkg::CSR_ROT_Y: begin
                  rot_ff[1] <= csr_wdata;
                  start_ff  <= 1'b1;
               end
               qpt_pkg::CSR_ROT_Z: begin
                  rot_ff[2] <= csr_wdata;
                  start_ff  <= 1'b1;
               end
               qpt_pkg::CSR_ROT_W: begin
                  rot_ff[3] <= csr_wdata;
                  start_ff  <= 1'b1;
               end
               qpt_pkg::CSR_TRANS_X: trans_ff[0] <= csr_wdata;
               qpt_pkg::CSR_TRANS_Y: trans_ff[1] <= csr_wdata;
               qpt_pkg::CSR_TRANS_Z: trans_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   qpt_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .rot    (rot_ff),
      .status (norm_status),
      .unit_q (unit_q)
   );

   // Move the pipeline whenever the output slot is free or being taken
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance || norm_status.busy || start_ff;

   assign p_in[0] = req_point_x;
   assign p_in[1] = req_point_y;
   assign p_in[2] = req_point_z;

   qpt_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid && !req_stall),
      .p_in      (p_in),
      .u         (unit_q),
      .t         (trans_ff),
      .out_valid (rsp_valid),
      .out_p     (out_p)
   );

   assign rsp_out_x = out_p[0];
   assign rsp_out_y = out_p[1];
   assign rsp_out_z = out_p[2];

   // No point enters while the unit quaternion is being rebuilt
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (norm_status.busy || start_ff) |-> req_stall)
      else $error("point taken during normalization");

   // A rotation write starts the normalizer or settles the identity at once
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> ##1 (norm_status.busy || unit_q[3] == qpt_pkg::QOne))
      else $error("normalizer did not start");

   // A held result stays valid and its x output stays put while the pipeline is frozen
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_x)))
      else $error("held result changed");

   // Reset empties the pipeline
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the quaternion point transform, with a built-in predictor.
module tb_top;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   typedef struct {
      point_type pt;
      bit        typed;
      point_type want;
   } stim_row_type;

   localparam logic [2:0]        CsrUnused = 3'd7;
   localparam qpt_pkg::word_type WordMax   = 32'sh7fff_ffff;
   localparam qpt_pkg::word_type WordMin   = 32'sh8000_0000;
   localparam int                IdleLimit = 5000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_point_x;
   logic [31:0] req_point_y;
   logic [31:0] req_point_z;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_out_x;
   logic [31:0] rsp_out_y;
   logic [31:0] rsp_out_z;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   // Shadow copy of the block's registers
   qpt_pkg::word_type quat_shadow [4];
   qpt_pkg::word_type shift_shadow [3];

   point_type moved_points [$];
   int        fail_count = 0;
   int        idle_cycles;
   int        stall_left;
   bit        calm;
   bit        row_typed;
   point_type row_want;

   quaternion_point_transform DUT (.*);

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Integer square root, floor
   function automatic longint unsigned root_floor(longint unsigned s);
      longint unsigned res;
      longint unsigned bitpos;
      res = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > s) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (s >= res + bitpos) begin
            s = s - (res + bitpos);
            res = (res >> 1) + bitpos;
         end else begin
            res = res >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return res;
   endfunction

   // Round to nearest, ties toward plus infinity
   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic qpt_pkg::word_type clamp_word(longint v);
      if (v > 64'sd2147483647) return WordMax;
      if (v < -64'sd2147483648) return WordMin;
      return qpt_pkg::word_type'(v);
   endfunction

   // Rotate by the normalized quaternion, then translate
   function automatic point_type transform_point(point_type pin);
      longint          c [4];
      longint          u [4];
      longint          p [3];
      longint          c1 [3];
      longint          c2 [3];
      longint unsigned m [4];
      longint unsigned mx;
      longint unsigned sq;
      longint unsigned len;
      longint          q;
      point_type       res;
      mx = 0;
      sq = 0;
      for (int i = 0; i < 4; i++) begin
         c[i] = longint'(quat_shadow[i]);
         m[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
         if (m[i] > 64'd2147483647) m[i] = 64'd2147483647;
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         u[0] = 0; u[1] = 0; u[2] = 0; u[3] = longint'(qpt_pkg::QOne);
      end else begin
         while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 4; i++) m[i] = m[i] << 1;
         end
         for (int i = 0; i < 4; i++) sq = sq + m[i] * m[i];
         len = root_floor(sq);
         for (int i = 0; i < 4; i++) begin
            q = longint'(((m[i] << 30) + (len >> 1)) / len);
            u[i] = (c[i] < 0) ? -q : q;
         end
      end
      p[0] = longint'(pin.x); p[1] = longint'(pin.y); p[2] = longint'(pin.z);
      c1[0] = round_shift(u[1] * p[2] - u[2] * p[1], 30);
      c1[1] = round_shift(u[2] * p[0] - u[0] * p[2], 30);
      c1[2] = round_shift(u[0] * p[1] - u[1] * p[0], 30);
      c2[0] = round_shift(u[1] * c1[2] - u[2] * c1[1], 30);
      c2[1] = round_shift(u[2] * c1[0] - u[0] * c1[2], 30);
      c2[2] = round_shift(u[0] * c1[1] - u[1] * c1[0], 30);
      res.x = clamp_word(p[0] + round_shift(u[3] * c1[0], 29) + 2 * c2[0]
                         + longint'(shift_shadow[0]));
      res.y = clamp_word(p[1] + round_shift(u[3] * c1[1], 29) + 2 * c2[1]
                         + longint'(shift_shadow[1]));
      res.z = clamp_word(p[2] + round_shift(u[3] * c1[2], 29) + 2 * c2[2]
                         + longint'(shift_shadow[2]));
      return res;
   endfunction

   // Idle length: mostly none, sometimes short, rarely long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 20);
   endfunction

   function automatic qpt_pkg::word_type pick_word();
      case ($urandom_range(5))
         0: return WordMax;
         1: return WordMin;
         2: return qpt_pkg::word_type'($urandom_range(2047)) - 1024;
         3: return qpt_pkg::word_type'($urandom_range(65535)) <<< $urandom_range(15);
         default: return qpt_pkg::word_type'($urandom);
      endcase
   endfunction

   // Drive one register write; the caller lowers csr_we after the last one
   task automatic write_reg(logic [2:0] idx, qpt_pkg::word_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         qpt_pkg::CSR_ROT_X:   quat_shadow[0] = val;
         qpt_pkg::CSR_ROT_Y:   quat_shadow[1] = val;
         qpt_pkg::CSR_ROT_Z:   quat_shadow[2] = val;
         qpt_pkg::CSR_ROT_W:   quat_shadow[3] = val;
         qpt_pkg::CSR_TRANS_X: shift_shadow[0] = val;
         qpt_pkg::CSR_TRANS_Y: shift_shadow[1] = val;
         qpt_pkg::CSR_TRANS_Z: shift_shadow[2] = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_transform(qpt_pkg::word_type qx, qpt_pkg::word_type qy,
                                 qpt_pkg::word_type qz, qpt_pkg::word_type qw,
                                 qpt_pkg::word_type tx, qpt_pkg::word_type ty,
                                 qpt_pkg::word_type tz);
      write_reg(qpt_pkg::CSR_ROT_X, qx);
      write_reg(qpt_pkg::CSR_ROT_Y, qy);
      write_reg(qpt_pkg::CSR_ROT_Z, qz);
      write_reg(qpt_pkg::CSR_ROT_W, qw);
      write_reg(qpt_pkg::CSR_TRANS_X, tx);
      write_reg(qpt_pkg::CSR_TRANS_Y, ty);
      write_reg(qpt_pkg::CSR_TRANS_Z, tz);
      write_reg(CsrUnused, qpt_pkg::word_type'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one point and hold it until the transfer
   task automatic send_point(point_type pt, bit typed, point_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      row_typed   <= typed;
      row_want    <= want;
      req_valid   <= 1'b1;
      req_point_x <= pt.x;
      req_point_y <= pt.y;
      req_point_z <= pt.z;
      do @(posedge clock); while (req_stall);
   endtask

   // Pause the sender until every expected point has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (moved_points.size() != 0) @(posedge clock);
   endtask

   // Record the expected point on each input transfer
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (row_typed)
            moved_points.push_back(row_want);
         else
            moved_points.push_back(transform_point({req_point_x, req_point_y, req_point_z}));
      end
   end

   // Result side: random stall, compare each transfer with the oldest expectation
   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (moved_points.size() == 0) begin
               $error("unexpected result %h %h %h", rsp_out_x, rsp_out_y, rsp_out_z);
               fail_count++;
            end else begin
               want = moved_points.pop_front();
               if (rsp_out_x !== want.x) begin
                  $error("out_x expected %0d actual %0d", want.x, $signed(rsp_out_x));
                  fail_count++;
               end
               if (rsp_out_y !== want.y) begin
                  $error("out_y expected %0d actual %0d", want.y, $signed(rsp_out_y));
                  fail_count++;
               end
               if (rsp_out_z !== want.z) begin
                  $error("out_z expected %0d actual %0d", want.z, $signed(rsp_out_z));
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else begin
            stall_left <= pick_gap();
            rsp_stall  <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   stim_row_type rows [12];

   initial begin
      point_type pt;
      calm        = 1'b0;
      row_typed   = 1'b0;
      row_want    = '0;
      quat_shadow  = '{0, 0, 0, qpt_pkg::QOne};
      shift_shadow = '{0, 0, 0};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_point_x = '0;
      req_point_y = '0;
      req_point_z = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;

      // Identity after reset: typed rows return the point unchanged
      rows[0]  = '{'{0, 0, 0}, 1, '{0, 0, 0}};
      rows[1]  = '{'{WordMax, WordMax, WordMax}, 1, '{WordMax, WordMax, WordMax}};
      rows[2]  = '{'{WordMin, WordMin, WordMin}, 1, '{WordMin, WordMin, WordMin}};
      rows[3]  = '{'{WordMax, WordMin, 0}, 1, '{WordMax, WordMin, 0}};
      rows[4]  = '{'{32'sh0001_0000, -32'sh0002_0000, 1}, 1,
                   '{32'sh0001_0000, -32'sh0002_0000, 1}};
      rows[5]  = '{'{-1, 32'sh5555_5555, 32'shaaaa_aaaa}, 1,
                   '{-1, 32'sh5555_5555, 32'shaaaa_aaaa}};
      rows[6]  = '{'{32'sh0003_8000, 32'sh0000_8000, -32'sh0000_8000}, 0, '0};
      rows[7]  = '{'{WordMax, 0, WordMin}, 0, '0};
      rows[8]  = '{'{-32'sh0010_0000, 32'sh0020_0000, 32'sh0030_0000}, 0, '0};
      rows[9]  = '{'{WordMin, WordMax, WordMax}, 0, '0};
      rows[10] = '{'{7, -7, 32'sh1234_5678}, 0, '0};
      rows[11] = '{'{WordMax, WordMax, WordMin}, 0, '0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_point(rows[i].pt, rows[i].typed, rows[i].want);
      drain();

      // Directed settings: half turn about z, zero quaternion with extreme shift,
      // most negative components, quarter turn about x
      for (int s = 0; s < 4; s++) begin
         case (s)
            0: load_transform(0, 0, qpt_pkg::QOne, 0, 32'sh0001_0000, 0, -32'sh0001_0000);
            1: load_transform(0, 0, 0, 0, WordMax, WordMin, 0);
            2: load_transform(WordMin, WordMin, WordMin, WordMin, WordMin, WordMax, 0);
            default: load_transform(qpt_pkg::QOne, 0, 0, qpt_pkg::QOne, 0, 0, WordMax);
         endcase
         for (int i = 6; i < 12; i++) send_point(rows[i].pt, 1'b0, '0);
         drain();
      end

      // Random phases under random settings
      for (int ph = 0; ph < 24; ph++) begin
         calm = ($urandom_range(4) == 0);
         case ($urandom_range(5))
            0: load_transform(0, 0, 0, 0, pick_word(), pick_word(), pick_word());
            1: load_transform(qpt_pkg::word_type'($urandom_range(15)) - 8,
                              qpt_pkg::word_type'($urandom_range(15)) - 8,
                              qpt_pkg::word_type'($urandom_range(15)) - 8,
                              qpt_pkg::word_type'($urandom_range(15)) - 8, 0, 0, 0);
            default: load_transform(pick_word(), pick_word(), pick_word(), pick_word(),
                                    pick_word(), pick_word(), pick_word());
         endcase
         for (int i = 0; i < 50; i++) begin
            pt.x = pick_word();
            pt.y = pick_word();
            pt.z = pick_word();
            send_point(pt, 1'b0, '0);
         end
         drain();
      end
      calm = 1'b0;

      // Let the pipeline settle
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[filelist.f]
sv/qpt_pkg.sv
sv/qpt_norm.sv
sv/qpt_rotate.sv
sv/quaternion_point_transform.sv
test/tb_top.sv
